// File: hw/rtl/qbt_pkg.sv
// Shared types, widths and constants for the quadratic Bezier tessellator.
// No dependencies; used by the top level and its checker.
`timescale 1ns / 1ps
`default_nettype none

package qbt_pkg;

  // Coordinate width (signed Q3.12 at 16 bits).
  localparam int CoordBits = 16;
  // Curve parameter t in 0..65536 (t = 1.0 is 65536).
  localparam int TBits     = 17;
  // Bernstein weights u*u, 2*u*t, t*t in 0..2^32.
  localparam int WBits     = 33;
  // Segment count register width.
  localparam int NBits     = 6;
  // Second multiplier operand covers both t and a coordinate.
  localparam int MulBBits  = (CoordBits > TBits) ? CoordBits : TBits;
  // Weighted coordinate sum plus rounding constant stays below 2^AccBits.
  localparam int AccBits   = WBits + CoordBits;
  // Divider walks the dividend bits from the top.
  localparam int DivBits   = 5;

  localparam logic [TBits-1:0]   TOne        = TBits'(65536);
  localparam logic [NBits-1:0]   SegResetVal = NBits'(32);
  localparam logic [DivBits-1:0] DivTop      = DivBits'(TBits - 1);
  localparam logic [AccBits-1:0] RoundHalf   = AccBits'(64'h8000_0000);

  // Sequencer steps of the shared multiplier during one curve point.
  localparam int CalcBits = 4;
  localparam logic [CalcBits-1:0] CS_UU  = 4'd0;  // u*u
  localparam logic [CalcBits-1:0] CS_TT  = 4'd1;  // t*t, latch w0
  localparam logic [CalcBits-1:0] CS_X0  = 4'd2;  // latch w2, w1; w0*x0
  localparam logic [CalcBits-1:0] CS_X1  = 4'd3;  // w1*x1
  localparam logic [CalcBits-1:0] CS_X2  = 4'd4;  // w2*x2
  localparam logic [CalcBits-1:0] CS_Y0  = 4'd5;  // w0*y0
  localparam logic [CalcBits-1:0] CS_Y1  = 4'd6;  // w1*y1
  localparam logic [CalcBits-1:0] CS_Y2  = 4'd7;  // w2*y2
  localparam logic [CalcBits-1:0] CS_FIN = 4'd8;  // last accumulate

  typedef enum logic [1:0] {
    PH_FIRST  = 2'd0,
    PH_MIDDLE = 2'd1,
    PH_END    = 2'd2
  } phase_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ERR,
    ST_START,
    ST_DIV,
    ST_STEP,
    ST_CALC,
    ST_EMIT
  } state_e;

  typedef enum logic [1:0] {
    SRC_ERR,
    SRC_START,
    SRC_CURVE
  } out_src_e;

  // Signed to offset binary and back (flip the sign bit).
  function automatic logic [CoordBits-1:0] to_biased(input logic [CoordBits-1:0] v);
    return {~v[CoordBits-1], v[CoordBits-2:0]};
  endfunction

  function automatic logic [CoordBits-1:0] from_biased(input logic [CoordBits-1:0] b);
    return {~b[CoordBits-1], b[CoordBits-2:0]};
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/quadratic_bezier_tessellator_top.sv
// Quadratic Bezier tessellator: control point chain in, curve points out.
// Depends on qbt_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake               Payload
// cfg       in         cfg_we_i (no wait)      cfg_segments_per_curve_i
// in        in         in_valid_i/in_ready_o   point_x_i, point_y_i, list_end_i
// out       out        out_valid_o/out_ready_i curve_x_o, curve_y_o, curve_done_o, bad_list_o
//
// First and middle control points are only stored; a list ending on one adds an error
// result. A segment end point occupies the block through ST_START (when the start point
// goes out first), the 17-step divider for the t increment, then per curve point ST_STEP,
// ST_CALC (the one shared 33x17 multiplier, used 8 times) and ST_EMIT; output stalls hold it.
// One finished point waits in the output register while the next is computed.
// Reset is asynchronous, active low; N comes back as 32.

module quadratic_bezier_tessellator_top (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  wire                                   cfg_we_i,
  input  wire        [qbt_pkg::NBits-1:0]       cfg_segments_per_curve_i,
  input  wire                                   in_valid_i,
  output logic                                  in_ready_o,
  input  wire signed [qbt_pkg::CoordBits-1:0]   point_x_i,
  input  wire signed [qbt_pkg::CoordBits-1:0]   point_y_i,
  input  wire                                   list_end_i,
  output logic                                  out_valid_o,
  input  wire                                   out_ready_i,
  output logic signed [qbt_pkg::CoordBits-1:0]  curve_x_o,
  output logic signed [qbt_pkg::CoordBits-1:0]  curve_y_o,
  output logic                                  curve_done_o,
  output logic                                  bad_list_o
);

  localparam int C = qbt_pkg::CoordBits;

  // ---------------- control state ----------------
  qbt_pkg::state_e state_q, state_d;
  qbt_pkg::phase_e phase_q, phase_d;
  logic            start_pending_q, start_pending_d;
  logic [qbt_pkg::NBits-1:0] seg_cfg_q;

  logic [qbt_pkg::NBits-1:0]    n_q;        // N latched per segment
  logic [qbt_pkg::DivBits-1:0]  div_idx_q;
  logic [qbt_pkg::NBits-1:0]    rem_q;      // 65536 mod N once divided
  logic [qbt_pkg::TBits-1:0]    quo_q;      // 65536 / N once divided
  logic [qbt_pkg::TBits-1:0]    t_q;        // round(j*65536/N)
  logic [qbt_pkg::NBits-1:0]    r_q;        // running remainder of t
  logic [qbt_pkg::NBits-1:0]    j_q;
  logic [qbt_pkg::CalcBits-1:0] calc_q;
  logic                         last_q;
  logic                         out_valid_q;

  // ---------------- payload ----------------
  logic [C-1:0] anchor_x_q, anchor_y_q, middle_x_q, middle_y_q, end_x_q, end_y_q;
  logic [qbt_pkg::AccBits-1:0] prod_q, acc_x_q, acc_y_q;
  logic [qbt_pkg::WBits-1:0]   w0_q, w1_q, w2_q;
  logic [C-1:0] out_x_q, out_y_q;
  logic         out_done_q, out_bad_q;

  // ---------------- control decode ----------------
  logic                  in_fire, out_fire, slot_free, out_load, seg_last;
  qbt_pkg::out_src_e     out_src;
  logic [qbt_pkg::NBits-1:0] n_new;

  assign in_fire   = in_valid_i && in_ready_o;
  assign out_fire  = out_valid_q && out_ready_i;
  assign slot_free = !out_valid_q || out_ready_i;
  assign seg_last  = (j_q == n_q);
  // A zero count register acts as one point per segment.
  assign n_new     = (seg_cfg_q == '0) ? qbt_pkg::NBits'(1) : seg_cfg_q;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      qbt_pkg::ST_IDLE: begin
        if (in_fire) begin
          case (phase_q)
            qbt_pkg::PH_MIDDLE: state_d = list_end_i ? qbt_pkg::ST_ERR : qbt_pkg::ST_IDLE;
            qbt_pkg::PH_END:    state_d = start_pending_q ? qbt_pkg::ST_START
                                                          : qbt_pkg::ST_DIV;
            default:            state_d = list_end_i ? qbt_pkg::ST_ERR : qbt_pkg::ST_IDLE;
          endcase
        end
      end
      qbt_pkg::ST_ERR:   if (slot_free) state_d = qbt_pkg::ST_IDLE;
      qbt_pkg::ST_START: if (slot_free) state_d = qbt_pkg::ST_DIV;
      qbt_pkg::ST_DIV:   if (div_idx_q == '0) state_d = qbt_pkg::ST_STEP;
      qbt_pkg::ST_STEP:  state_d = qbt_pkg::ST_CALC;
      qbt_pkg::ST_CALC:  if (calc_q == qbt_pkg::CS_FIN) state_d = qbt_pkg::ST_EMIT;
      qbt_pkg::ST_EMIT: begin
        if (slot_free) state_d = seg_last ? qbt_pkg::ST_IDLE : qbt_pkg::ST_STEP;
      end
      default: state_d = qbt_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    in_ready_o = 1'b0;
    out_load   = 1'b0;
    out_src    = qbt_pkg::SRC_CURVE;
    case (state_q)
      qbt_pkg::ST_IDLE:  in_ready_o = 1'b1;
      qbt_pkg::ST_ERR: begin
        out_load = slot_free;
        out_src  = qbt_pkg::SRC_ERR;
      end
      qbt_pkg::ST_START: begin
        out_load = slot_free;
        out_src  = qbt_pkg::SRC_START;
      end
      qbt_pkg::ST_EMIT:  out_load = slot_free;
      default: ;
    endcase
  end

  // Curve phase and start-point flag
  always_comb begin
    phase_d         = phase_q;
    start_pending_d = start_pending_q;
    if (in_fire) begin
      case (phase_q)
        qbt_pkg::PH_MIDDLE: begin
          phase_d = list_end_i ? qbt_pkg::PH_FIRST : qbt_pkg::PH_END;
          if (list_end_i) start_pending_d = 1'b1;
        end
        qbt_pkg::PH_END: ;
        default: begin
          phase_d         = list_end_i ? qbt_pkg::PH_FIRST : qbt_pkg::PH_MIDDLE;
          start_pending_d = 1'b1;
        end
      endcase
    end
    if (state_q == qbt_pkg::ST_START && slot_free) start_pending_d = 1'b0;
    if (state_q == qbt_pkg::ST_EMIT && slot_free && seg_last) begin
      phase_d         = last_q ? qbt_pkg::PH_FIRST : qbt_pkg::PH_MIDDLE;
      start_pending_d = last_q;
    end
  end

  // ---------------- divider: 65536 / N, one bit a cycle ----------------
  logic [qbt_pkg::NBits:0]   div_shift;
  logic                      div_ge;
  logic [qbt_pkg::NBits-1:0] div_rem;
  assign div_shift = {rem_q, qbt_pkg::TOne[div_idx_q]};
  assign div_ge    = (div_shift >= {1'b0, n_q});
  assign div_rem   = div_ge ? qbt_pkg::NBits'(div_shift - {1'b0, n_q})
                          : div_shift[qbt_pkg::NBits-1:0];

  // t advance: t += Q, with carry from the remainder
  logic [qbt_pkg::NBits:0]   step_sum;
  logic                      step_wrap;
  logic [qbt_pkg::NBits-1:0] step_rem;
  assign step_sum  = {1'b0, r_q} + {1'b0, rem_q};
  assign step_wrap = (step_sum >= {1'b0, n_q});
  assign step_rem  = step_wrap ? qbt_pkg::NBits'(step_sum - {1'b0, n_q})
                               : step_sum[qbt_pkg::NBits-1:0];

  // ---------------- shared multiplier ----------------
  logic [qbt_pkg::TBits-1:0]             u_val;
  logic [qbt_pkg::WBits-1:0]             mul_a;
  logic [qbt_pkg::MulBBits-1:0]          mul_b;
  logic [qbt_pkg::WBits+qbt_pkg::MulBBits-1:0] mul_full;
  logic [qbt_pkg::WBits:0]               w1_full;

  assign u_val = qbt_pkg::TOne - t_q;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (calc_q)
      qbt_pkg::CS_UU: begin
        mul_a = qbt_pkg::WBits'(u_val);
        mul_b = qbt_pkg::MulBBits'(u_val);
      end
      qbt_pkg::CS_TT: begin
        mul_a = qbt_pkg::WBits'(t_q);
        mul_b = qbt_pkg::MulBBits'(t_q);
      end
      qbt_pkg::CS_X0: begin
        mul_a = w0_q;
        mul_b = qbt_pkg::MulBBits'(qbt_pkg::to_biased(anchor_x_q));
      end
      qbt_pkg::CS_X1: begin
        mul_a = w1_q;
        mul_b = qbt_pkg::MulBBits'(qbt_pkg::to_biased(middle_x_q));
      end
      qbt_pkg::CS_X2: begin
        mul_a = w2_q;
        mul_b = qbt_pkg::MulBBits'(qbt_pkg::to_biased(end_x_q));
      end
      qbt_pkg::CS_Y0: begin
        mul_a = w0_q;
        mul_b = qbt_pkg::MulBBits'(qbt_pkg::to_biased(anchor_y_q));
      end
      qbt_pkg::CS_Y1: begin
        mul_a = w1_q;
        mul_b = qbt_pkg::MulBBits'(qbt_pkg::to_biased(middle_y_q));
      end
      qbt_pkg::CS_Y2: begin
        mul_a = w2_q;
        mul_b = qbt_pkg::MulBBits'(qbt_pkg::to_biased(end_y_q));
      end
      default: ;
    endcase
  end

  assign mul_full = mul_a * mul_b;
  // 2ut = 2^32 - u^2 - t^2 since u + t = 2^16
  assign w1_full  = (qbt_pkg::WBits+1)'(64'h1_0000_0000) - {1'b0, w0_q}
                  - {1'b0, prod_q[qbt_pkg::WBits-1:0]};

  // ---------------- round half up and saturate ----------------
  logic [qbt_pkg::AccBits-1:0] rnd_x, rnd_y;
  logic [C:0]                  r_x, r_y;
  logic [C-1:0]                sat_x, sat_y;
  assign rnd_x = acc_x_q + qbt_pkg::RoundHalf;
  assign rnd_y = acc_y_q + qbt_pkg::RoundHalf;
  assign r_x   = rnd_x[qbt_pkg::AccBits-1:32];
  assign r_y   = rnd_y[qbt_pkg::AccBits-1:32];
  assign sat_x = r_x[C] ? '1 : r_x[C-1:0];
  assign sat_y = r_y[C] ? '1 : r_y[C-1:0];

  // ---------------- control registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= qbt_pkg::ST_IDLE;
      phase_q         <= qbt_pkg::PH_FIRST;
      start_pending_q <= 1'b1;
      seg_cfg_q       <= qbt_pkg::SegResetVal;
      out_valid_q     <= 1'b0;
      n_q             <= qbt_pkg::NBits'(1);
      div_idx_q       <= '0;
      rem_q           <= '0;
      quo_q           <= '0;
      t_q             <= '0;
      r_q             <= '0;
      j_q             <= '0;
      calc_q          <= '0;
      last_q          <= 1'b0;
    end else begin
      state_q         <= state_d;
      phase_q         <= phase_d;
      start_pending_q <= start_pending_d;
      if (cfg_we_i) seg_cfg_q <= cfg_segments_per_curve_i;

      if (out_load)      out_valid_q <= 1'b1;
      else if (out_fire) out_valid_q <= 1'b0;

      if (in_fire && phase_q == qbt_pkg::PH_END) begin
        last_q    <= list_end_i;
        n_q       <= n_new;
        div_idx_q <= qbt_pkg::DivTop;
        rem_q     <= '0;
        quo_q     <= '0;
        t_q       <= '0;
        r_q       <= n_new >> 1;
        j_q       <= qbt_pkg::NBits'(1);
      end

      if (state_q == qbt_pkg::ST_DIV) begin
        rem_q     <= div_rem;
        quo_q     <= {quo_q[qbt_pkg::TBits-2:0], div_ge};
        div_idx_q <= div_idx_q - qbt_pkg::DivBits'(1);
      end

      if (state_q == qbt_pkg::ST_STEP) begin
        r_q    <= step_rem;
        t_q    <= t_q + quo_q + qbt_pkg::TBits'(step_wrap);
        calc_q <= qbt_pkg::CS_UU;
      end

      if (state_q == qbt_pkg::ST_CALC) calc_q <= calc_q + qbt_pkg::CalcBits'(1);

      if (state_q == qbt_pkg::ST_EMIT && slot_free && !seg_last)
        j_q <= j_q + qbt_pkg::NBits'(1);
    end
  end

  // ---------------- payload registers ----------------
  always_ff @(posedge clk_i) begin
    prod_q <= mul_full[qbt_pkg::AccBits-1:0];

    if (in_fire) begin
      case (phase_q)
        qbt_pkg::PH_MIDDLE: begin
          middle_x_q <= point_x_i;
          middle_y_q <= point_y_i;
        end
        qbt_pkg::PH_END: begin
          end_x_q <= point_x_i;
          end_y_q <= point_y_i;
        end
        default: begin
          anchor_x_q <= point_x_i;
          anchor_y_q <= point_y_i;
        end
      endcase
    end

    if (state_q == qbt_pkg::ST_CALC) begin
      case (calc_q)
        qbt_pkg::CS_TT: w0_q <= prod_q[qbt_pkg::WBits-1:0];
        qbt_pkg::CS_X0: begin
          w2_q <= prod_q[qbt_pkg::WBits-1:0];
          w1_q <= w1_full[qbt_pkg::WBits-1:0];
        end
        qbt_pkg::CS_X1:  acc_x_q <= prod_q;
        qbt_pkg::CS_X2:  acc_x_q <= acc_x_q + prod_q;
        qbt_pkg::CS_Y0:  acc_x_q <= acc_x_q + prod_q;
        qbt_pkg::CS_Y1:  acc_y_q <= prod_q;
        qbt_pkg::CS_Y2:  acc_y_q <= acc_y_q + prod_q;
        qbt_pkg::CS_FIN: acc_y_q <= acc_y_q + prod_q;
        default: ;
      endcase
    end

    // Segment end becomes the next segment's anchor
    if (state_q == qbt_pkg::ST_EMIT && slot_free && seg_last) begin
      anchor_x_q <= end_x_q;
      anchor_y_q <= end_y_q;
    end

    if (out_load) begin
      case (out_src)
        qbt_pkg::SRC_ERR: begin
          out_x_q    <= '0;
          out_y_q    <= '0;
          out_done_q <= 1'b1;
          out_bad_q  <= 1'b1;
        end
        qbt_pkg::SRC_START: begin
          out_x_q    <= anchor_x_q;
          out_y_q    <= anchor_y_q;
          out_done_q <= 1'b0;
          out_bad_q  <= 1'b0;
        end
        default: begin
          out_x_q    <= qbt_pkg::from_biased(sat_x);
          out_y_q    <= qbt_pkg::from_biased(sat_y);
          out_done_q <= last_q && seg_last;
          out_bad_q  <= 1'b0;
        end
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign curve_x_o    = out_x_q;
  assign curve_y_o    = out_y_q;
  assign curve_done_o = out_done_q;
  assign bad_list_o   = out_bad_q;

endmodule

`default_nettype wire

// File: hw/rtl/qbt_checker.sv
// Port-level checks for the tessellator top, attached by bind.
// Depends on qbt_pkg and quadratic_bezier_tessellator_top.
`timescale 1ns / 1ps
`default_nettype none

module qbt_checker (
  input wire                               clk_i,
  input wire                               rst_ni,
  input wire                               cfg_we_i,
  input wire [qbt_pkg::NBits-1:0]          cfg_segments_per_curve_i,
  input wire                               in_valid_i,
  input wire                               in_ready_o,
  input wire [qbt_pkg::CoordBits-1:0]      point_x_i,
  input wire [qbt_pkg::CoordBits-1:0]      point_y_i,
  input wire                               list_end_i,
  input wire                               out_valid_o,
  input wire                               out_ready_i,
  input wire [qbt_pkg::CoordBits-1:0]      curve_x_o,
  input wire [qbt_pkg::CoordBits-1:0]      curve_y_o,
  input wire                               curve_done_o,
  input wire                               bad_list_o
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(curve_x_o)
      && $stable(curve_y_o) && $stable(curve_done_o) && $stable(bad_list_o))
    else $error("stalled result changed");

  // Error result carries zeros and closes the curve.
  a_err_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && bad_list_o |-> curve_done_o && curve_x_o == '0 && curve_y_o == '0)
    else $error("malformed error result");

  // A closing point always leads to output work, so the input stalls.
  a_last_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && list_end_i |=> !in_ready_o)
    else $error("input ready right after closing point");

  // An error result only follows a closing point.
  a_err_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) && bad_list_o |-> $past(list_end_i, 2) || $past(list_end_i, 1))
    else $error("error result without closing point");

endmodule

bind quadratic_bezier_tessellator_top qbt_checker u_qbt_checker (.*);

`default_nettype wire

// File: test/qbt_checker.sv
// Checker for the quadratic Bezier tessellator: watches the config, point and
// curve channels, predicts every curve point and compares field by field.
// Depends on qbt_pkg for widths, the phase enum and the segment reset value.
`timescale 1ns / 1ps

module qbt_tb_checker (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  wire                                   cfg_we_i,
  input  wire [qbt_pkg::NBits-1:0]              cfg_segments_per_curve_i,
  input  wire                                   in_valid_i,
  input  wire                                   in_ready_i,
  input  wire [qbt_pkg::CoordBits-1:0]          point_x_i,
  input  wire [qbt_pkg::CoordBits-1:0]          point_y_i,
  input  wire                                   list_end_i,
  input  wire                                   out_valid_i,
  input  wire                                   out_ready_i,
  input  wire [qbt_pkg::CoordBits-1:0]          curve_x_i,
  input  wire [qbt_pkg::CoordBits-1:0]          curve_y_i,
  input  wire                                   curve_done_i,
  input  wire                                   bad_list_i,
  output int                                    fail_count_o,
  output int                                    pending_o
);

  localparam logic [qbt_pkg::CoordBits-1:0] SignFlip =
    {1'b1, {(qbt_pkg::CoordBits-1){1'b0}}};
  localparam logic [63:0] CoordMax = (64'd1 << qbt_pkg::CoordBits) - 64'd1;
  localparam logic [63:0] TUnit    = 64'd65536;

  typedef struct packed {
    logic [qbt_pkg::CoordBits-1:0] x;
    logic [qbt_pkg::CoordBits-1:0] y;
    logic                          done;
    logic                          bad;
  } curve_pt_t;

  curve_pt_t                     pending_points[$];
  logic [qbt_pkg::NBits-1:0]     seg_count;
  logic [qbt_pkg::CoordBits-1:0] anchor_x, anchor_y, middle_x, middle_y;
  qbt_pkg::phase_e               phase;
  logic                          start_pending;
  int                            mismatches;

  // Weighted sum in offset binary; weights add up to 2^32, round half up.
  function automatic logic [qbt_pkg::CoordBits-1:0] bezier_coord(
    input logic [qbt_pkg::CoordBits-1:0] p0,
    input logic [qbt_pkg::CoordBits-1:0] p1,
    input logic [qbt_pkg::CoordBits-1:0] p2,
    input logic [63:0]                   t
  );
    logic [63:0] u, acc, r;
    u   = TUnit - t;
    acc = u * u * (p0 ^ SignFlip) + 2 * u * t * (p1 ^ SignFlip)
        + t * t * (p2 ^ SignFlip);
    r   = (acc + 64'h8000_0000) >> 32;
    if (r > CoordMax) r = CoordMax;
    return r[qbt_pkg::CoordBits-1:0] ^ SignFlip;
  endfunction

  task automatic push_point(input logic [qbt_pkg::CoordBits-1:0] x,
                            input logic [qbt_pkg::CoordBits-1:0] y,
                            input logic done, input logic bad);
    curve_pt_t pt;
    pt.x    = x;
    pt.y    = y;
    pt.done = done;
    pt.bad  = bad;
    pending_points.push_back(pt);
  endtask

  task automatic list_error();
    push_point('0, '0, 1'b1, 1'b1);
    phase         = qbt_pkg::PH_FIRST;
    start_pending = 1'b1;
  endtask

  task automatic tessellate_point(input logic [qbt_pkg::CoordBits-1:0] px,
                                  input logic [qbt_pkg::CoordBits-1:0] py,
                                  input logic last);
    logic [63:0] n, t, j;
    case (phase)
      qbt_pkg::PH_MIDDLE: begin
        middle_x = px;
        middle_y = py;
        if (last) list_error();
        else phase = qbt_pkg::PH_END;
      end
      qbt_pkg::PH_END: begin
        n = seg_count;
        if (n == 0) n = 1;
        if (start_pending) begin
          push_point(anchor_x, anchor_y, 1'b0, 1'b0);
          start_pending = 1'b0;
        end
        for (j = 1; j <= n; j++) begin
          t = (j * TUnit + n / 2) / n;
          push_point(bezier_coord(anchor_x, middle_x, px, t),
                     bezier_coord(anchor_y, middle_y, py, t), last && (j == n), 1'b0);
        end
        anchor_x = px;
        anchor_y = py;
        if (last) begin
          phase         = qbt_pkg::PH_FIRST;
          start_pending = 1'b1;
        end else begin
          phase = qbt_pkg::PH_MIDDLE;
        end
      end
      default: begin
        anchor_x      = px;
        anchor_y      = py;
        start_pending = 1'b1;
        if (last) list_error();
        else phase = qbt_pkg::PH_MIDDLE;
      end
    endcase
  endtask

  task automatic check_point();
    curve_pt_t want;
    if (pending_points.size() == 0) begin
      $error("curve point with none expected: x=%0d y=%0d done=%0b bad=%0b",
             $signed(curve_x_i), $signed(curve_y_i), curve_done_i, bad_list_i);
      mismatches++;
    end else begin
      want = pending_points.pop_front();
      if (curve_x_i !== want.x) begin
        $error("curve_x: expected %0d, got %0d", $signed(want.x), $signed(curve_x_i));
        mismatches++;
      end
      if (curve_y_i !== want.y) begin
        $error("curve_y: expected %0d, got %0d", $signed(want.y), $signed(curve_y_i));
        mismatches++;
      end
      if (curve_done_i !== want.done) begin
        $error("curve_done: expected %0b, got %0b", want.done, curve_done_i);
        mismatches++;
      end
      if (bad_list_i !== want.bad) begin
        $error("bad_list: expected %0b, got %0b", want.bad, bad_list_i);
        mismatches++;
      end
    end
  endtask

  // Output side first: a point accepted at this edge cannot come from the
  // control point accepted at the same edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_points.delete();
      seg_count     = qbt_pkg::SegResetVal;
      anchor_x      = '0;
      anchor_y      = '0;
      middle_x      = '0;
      middle_y      = '0;
      phase         = qbt_pkg::PH_FIRST;
      start_pending = 1'b1;
      mismatches    = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_we_i) seg_count = cfg_segments_per_curve_i;
      if (out_valid_i && out_ready_i) check_point();
      if (in_valid_i && in_ready_i) tessellate_point(point_x_i, point_y_i, list_end_i);
      fail_count_o <= mismatches;
      pending_o    <= pending_points.size();
    end
  end

endmodule

// File: test/quadratic_bezier_tessellator_top_tb.sv
// Testbench top for the quadratic Bezier tessellator: reset, config writes,
// control point stimulus with random idling, and the verdict.
// Depends on qbt_pkg, quadratic_bezier_tessellator_top and qbt_tb_checker.
`timescale 1ns / 1ps

module quadratic_bezier_tessellator_top_tb;

  localparam int HalfPeriodNs = 10;
  localparam int ResetCycles  = 11;
  // Margin once the last curve point is out, for anything still in flight, such
  // as a trailing first or middle point or an error result.
  localparam int DrainCycles  = 16;
  // Long output hold-off so the block backs up into its input.
  localparam int HoldCycles   = 400;
  // Well above the worst correct run, which has segment ends at N = 63 and stalled
  // output points.
  localparam int LimitNs      = 30_000_000;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_we;
  logic [qbt_pkg::NBits-1:0]     cfg_segments;
  logic                          in_valid;
  logic                          in_ready;
  logic [qbt_pkg::CoordBits-1:0] point_x;
  logic [qbt_pkg::CoordBits-1:0] point_y;
  logic                          list_end;
  logic                          out_valid;
  logic                          out_ready;
  logic [qbt_pkg::CoordBits-1:0] curve_x;
  logic [qbt_pkg::CoordBits-1:0] curve_y;
  logic                          curve_done;
  logic                          bad_list;
  int                            fail_count;
  int                            pending;

  // Flags shared by sender and receiver; rx_stall is the receiver's alone.
  logic steady_tail = 1'b0;  // no idling on either side in the last stretch
  logic hold_output = 1'b0;  // one-shot request for the long output hold-off
  int   rx_stall;

  quadratic_bezier_tessellator_top dut (
    .clk_i                    (clk_i),
    .rst_ni                   (rst_ni),
    .cfg_we_i                 (cfg_we),
    .cfg_segments_per_curve_i (cfg_segments),
    .in_valid_i               (in_valid),
    .in_ready_o               (in_ready),
    .point_x_i                (point_x),
    .point_y_i                (point_y),
    .list_end_i               (list_end),
    .out_valid_o              (out_valid),
    .out_ready_i              (out_ready),
    .curve_x_o                (curve_x),
    .curve_y_o                (curve_y),
    .curve_done_o             (curve_done),
    .bad_list_o               (bad_list)
  );

  qbt_tb_checker checker_i (
    .clk_i                    (clk_i),
    .rst_ni                   (rst_ni),
    .cfg_we_i                 (cfg_we),
    .cfg_segments_per_curve_i (cfg_segments),
    .in_valid_i               (in_valid),
    .in_ready_i               (in_ready),
    .point_x_i                (point_x),
    .point_y_i                (point_y),
    .list_end_i               (list_end),
    .out_valid_i              (out_valid),
    .out_ready_i              (out_ready),
    .curve_x_i                (curve_x),
    .curve_y_i                (curve_y),
    .curve_done_i             (curve_done),
    .bad_list_i               (bad_list),
    .fail_count_o             (fail_count),
    .pending_o                (pending)
  );

  always begin
    clk_i = 1'b0;
    #(HalfPeriodNs);
    clk_i = 1'b1;
    #(HalfPeriodNs);
  end

  // Coordinates: mostly uniform over the full range (every bit toggles),
  // with the extremes, zero and minus one mixed in.
  function automatic logic [qbt_pkg::CoordBits-1:0] rand_coord();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 9))
      0:       return {1'b1, {(qbt_pkg::CoordBits-1){1'b0}}};
      1:       return {1'b0, {(qbt_pkg::CoordBits-1){1'b1}}};
      2:       return '0;
      3:       return '1;
      default: return r[qbt_pkg::CoordBits-1:0];
    endcase
  endfunction

  // One control point transfer; valid may drop for a random burst first, and
  // once raised it stays up with the payload held until in_ready.
  task automatic send_point(input logic [qbt_pkg::CoordBits-1:0] x,
                            input logic [qbt_pkg::CoordBits-1:0] y,
                            input logic last);
    if (!steady_tail && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    point_x  <= x;
    point_y  <= y;
    list_end <= last;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
  endtask

  // Drop valid and wait until every predicted curve point has been seen.
  // The extra edge up front lets the checker count the last transfer.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Only called with the block idle; a value of 0 means one point per segment.
  task automatic set_segments(input int n);
    cfg_we       <= 1'b1;
    cfg_segments <= n[qbt_pkg::NBits-1:0];
    @(posedge clk_i);
    cfg_we       <= 1'b0;
  endtask

  // Mostly well-formed curves (odd count, 3..9 points) with random content,
  // the rest too short or even-length so they end in the error result.
  task automatic send_random_curves(input int budget);
    int sent, len, k, kind;
    sent = 0;
    while (sent < budget) begin
      kind = $urandom_range(0, 9);
      if (kind < 8)       len = 2 * $urandom_range(1, 4) + 1;
      else if (kind == 8) len = $urandom_range(1, 2);
      else                len = 2 * $urandom_range(2, 4);
      for (k = 0; k < len; k++) send_point(rand_coord(), rand_coord(), k == len - 1);
      sent += len;
    end
  endtask

  task automatic run_phase(input int n, input int budget, input logic press);
    wait_idle();
    set_segments(n);
    if (press) hold_output = 1'b1;
    send_random_curves(budget);
  endtask

  // Receiver: random ready bursts, plus the one long hold-off on request.
  initial begin
    out_ready <= 1'b0;
    rx_stall = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_output) begin
        hold_output = 1'b0;
        rx_stall    = HoldCycles;
      end else if (rx_stall == 0 && !steady_tail && $urandom_range(0, 7) == 0) begin
        rx_stall = $urandom_range(1, 8);
      end
      if (rx_stall != 0) begin
        out_ready <= 1'b0;
        rx_stall--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Sender and verdict.
  initial begin
    rst_ni       <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_segments <= '0;
    in_valid     <= 1'b0;
    point_x      <= '0;
    point_y      <= '0;
    list_end     <= 1'b0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed, at the reset segment count of 32.
    // Three-point curve on the corners of the coordinate range.
    send_point(16'h8000, 16'h7fff, 1'b0);
    send_point(16'h7fff, 16'h8000, 1'b0);
    send_point(16'h7fff, 16'h7fff, 1'b1);
    // Single point: list ends while expecting the first point.
    send_point(16'h0000, 16'h0000, 1'b1);
    // Two points: list ends on a middle point.
    send_point(16'hffff, 16'h0001, 1'b0);
    send_point(16'h3039, 16'hcfc7, 1'b1);
    // Four points: one good segment goes out, then the error result.
    send_point(16'h8000, 16'h8000, 1'b0);
    send_point(16'h0000, 16'h0000, 1'b0);
    send_point(16'h7fff, 16'h7fff, 1'b0);
    send_point(16'h0064, 16'hff9c, 1'b1);
    // Five points: two chained segments, start point only once.
    send_point(16'h1234, 16'hedcb, 1'b0);
    send_point(16'h5555, 16'haaaa, 1'b0);
    send_point(16'haaaa, 16'h5555, 1'b0);
    send_point(16'h7fff, 16'h8000, 1'b0);
    send_point(16'h0000, 16'hffff, 1'b1);
    // New count written mid-curve takes effect at the next segment end.
    send_point(16'hc000, 16'h4000, 1'b0);
    send_point(16'h4000, 16'hc000, 1'b0);
    wait_idle();
    set_segments(4);
    send_point(16'h2000, 16'h2000, 1'b1);

    // Random phases across counts: zero (treated as one), the extremes, and
    // a few in between. The long output hold-off lands in the second phase.
    run_phase(0, 22, 1'b0);
    run_phase(1, 24, 1'b1);
    run_phase(63, 18, 1'b0);
    run_phase(2, 22, 1'b0);
    run_phase($urandom_range(1, 63), 20, 1'b0);
    run_phase(7, 20, 1'b0);
    steady_tail = 1'b1;
    run_phase(3, 20, 1'b0);

    wait_idle();
    if (fail_count == 0) begin
      $display("quadratic_bezier_tessellator_top_tb passed");
    end else begin
      $display("quadratic_bezier_tessellator_top_tb failed");
    end
    $finish;
  end

  initial begin
    #(LimitNs);
    $display("quadratic_bezier_tessellator_top_tb failed");
    $finish;
  end

endmodule
